// ----- rtl/core/sdp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the step/direction pulse generator.
// No dependencies; the register bank, the engine and the top level import this package.
package sdp_pkg;

    localparam int unsigned PosW  = 16;
    localparam int unsigned TickW = 16;
    localparam int unsigned AddrW = 4;
    localparam int unsigned DataW = 32;

    // Register indexes, byte address is 4 * index
    localparam logic [1:0] REG_MAX_POSITION     = 2'd0;
    localparam logic [1:0] REG_PULSE_HIGH_TICKS = 2'd1;
    localparam logic [1:0] REG_PULSE_LOW_TICKS  = 2'd2;
    localparam logic [1:0] REG_DIR_SETTLE_TICKS = 2'd3;

    localparam logic [PosW-1:0]  RST_MAX_POSITION     = 16'd65535;
    localparam logic [TickW-1:0] RST_PULSE_HIGH_TICKS = 16'd5000;
    localparam logic [TickW-1:0] RST_PULSE_LOW_TICKS  = 16'd2500;
    localparam logic [TickW-1:0] RST_DIR_SETTLE_TICKS = 16'd10000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_HIGH   = 4'b0100,
        PH_LOW    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [PosW-1:0]  max_position;
        logic [TickW-1:0] pulse_high_ticks;
        logic [TickW-1:0] pulse_low_ticks;
        logic [TickW-1:0] dir_settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic            cmd;
        logic            move_toward_max;
        logic [PosW-1:0] move_count;
    } item_t;

    typedef struct packed {
        logic            step_level;
        logic            dir_level;
        logic [PosW-1:0] position;
        logic [PosW-1:0] steps_remaining;
        logic            busy_res;
        logic            move_rejected;
        logic            move_clamped;
    } res_t;

endpackage

// ----- rtl/core/sdp_cmd_if.sv -----
`timescale 1ns / 1ps
// Input channel of the pulse generator: tick and move items.
// Standalone valid/ready interface, no package dependency.
interface sdp_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        move_toward_max;
    logic [15:0] move_count;

    modport source (output valid, output cmd, output move_toward_max,
                    output move_count, input ready);
    modport sink   (input valid, input cmd, input move_toward_max,
                    input move_count, output ready);
endinterface

// ----- rtl/core/sdp_res_if.sv -----
`timescale 1ns / 1ps
// Result channel of the pulse generator: one status item per input item.
// Standalone valid/ready interface, no package dependency.
interface sdp_res_if;
    logic        valid;
    logic        ready;
    logic        step_level;
    logic        dir_level;
    logic [15:0] position;
    logic [15:0] steps_remaining;
    logic        busy_res;
    logic        move_rejected;
    logic        move_clamped;

    modport source (output valid, output step_level, output dir_level,
                    output position, output steps_remaining, output busy_res,
                    output move_rejected, output move_clamped, input ready);
    modport sink   (input valid, input step_level, input dir_level,
                    input position, input steps_remaining, input busy_res,
                    input move_rejected, input move_clamped, output ready);
endinterface

// ----- rtl/core/sdp_cfg_regs.sv -----
`timescale 1ns / 1ps
// APB register bank: travel limit and the three tick lengths.
// Depends on sdp_pkg.
module sdp_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sdp_pkg::AddrW-1:0]  paddr,
    input  logic [sdp_pkg::DataW-1:0]  pwdata,
    output logic [sdp_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output sdp_pkg::cfg_t              cfg
);
    import sdp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MAX_POSITION:     cfg_next.max_position     = pwdata[PosW-1:0];
                REG_PULSE_HIGH_TICKS: cfg_next.pulse_high_ticks = pwdata[TickW-1:0];
                REG_PULSE_LOW_TICKS:  cfg_next.pulse_low_ticks  = pwdata[TickW-1:0];
                REG_DIR_SETTLE_TICKS: cfg_next.dir_settle_ticks = pwdata[TickW-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_POSITION:     prdata = {16'd0, cfg_reg.max_position};
            REG_PULSE_HIGH_TICKS: prdata = {16'd0, cfg_reg.pulse_high_ticks};
            REG_PULSE_LOW_TICKS:  prdata = {16'd0, cfg_reg.pulse_low_ticks};
            REG_DIR_SETTLE_TICKS: prdata = {16'd0, cfg_reg.dir_settle_ticks};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_position     <= RST_MAX_POSITION;
            cfg_reg.pulse_high_ticks <= RST_PULSE_HIGH_TICKS;
            cfg_reg.pulse_low_ticks  <= RST_PULSE_LOW_TICKS;
            cfg_reg.dir_settle_ticks <= RST_DIR_SETTLE_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/sdp_engine.sv -----
`timescale 1ns / 1ps
// Motion state (position, pulse count, direction, phase, timer) and the
// combinational update for one tick or move item. Depends on sdp_pkg.
module sdp_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  sdp_pkg::item_t item,
    input  sdp_pkg::cfg_t  cfg,
    output sdp_pkg::res_t  res
);
    import sdp_pkg::*;

    logic [PosW-1:0]  position_reg,  position_next;
    logic [PosW-1:0]  pulses_reg,    pulses_next;
    logic             dir_reg,       dir_next;
    phase_t           phase_reg,     phase_next;
    logic [TickW-1:0] timer_reg,     timer_next;

    logic [PosW-1:0]  room;
    logic [PosW-1:0]  grant;
    logic [TickW-1:0] timer_dec;
    logic             rejected;
    logic             clamped;

    function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
        at_least_one = (v == '0) ? TickW'(1) : v;
    endfunction

    // Clamp the request against the soft limits
    always_comb
    begin
        room = (position_reg < cfg.max_position) ? (cfg.max_position - position_reg) : '0;
        if (item.move_toward_max)
            grant = (item.move_count < room) ? item.move_count : room;
        else
            grant = (item.move_count < position_reg) ? item.move_count : position_reg;
    end

    assign timer_dec = (timer_reg != '0) ? (timer_reg - TickW'(1)) : timer_reg;

    always_comb
    begin
        position_next = position_reg;
        pulses_next   = pulses_reg;
        dir_next      = dir_reg;
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        rejected      = 1'b0;
        clamped       = 1'b0;

        if (item.cmd == CMD_MOVE)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                position_next = item.move_toward_max ? (position_reg + grant)
                                                     : (position_reg - grant);
                clamped       = (grant < item.move_count);
                pulses_next   = grant;
                dir_next      = item.move_toward_max;
                phase_next    = PH_SETTLE;
                timer_next    = at_least_one(cfg.dir_settle_ticks);
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        if (pulses_reg != '0)
                            pulses_next = pulses_reg - PosW'(1);
                        phase_next = PH_LOW;
                        timer_next = at_least_one(cfg.pulse_low_ticks);
                    end
                    default:
                    begin
                        if (pulses_reg != '0)
                        begin
                            phase_next = PH_HIGH;
                            timer_next = at_least_one(cfg.pulse_high_ticks);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.step_level      = (phase_next == PH_HIGH);
        res.dir_level       = dir_next;
        res.position        = position_next;
        res.steps_remaining = pulses_next;
        res.busy_res        = (phase_next != PH_IDLE);
        res.move_rejected   = rejected;
        res.move_clamped    = clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            pulses_reg   <= '0;
            dir_reg      <= 1'b1;
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
        end
        else if (fire)
        begin
            position_reg <= position_next;
            pulses_reg   <= pulses_next;
            dir_reg      <= dir_next;
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
        end
    end

endmodule

// ----- rtl/core/stepper_step_dir_pulser_top.sv -----
`timescale 1ns / 1ps
// Top level of the step/direction pulse generator with soft travel limits.
// Depends on sdp_pkg, sdp_cmd_if, sdp_res_if, sdp_cfg_regs, sdp_engine.
//
//   channel   role     handshake         carries
//   -------   ------   ---------------   ----------------------------------------
//   cmd_ch    sink     valid/ready       cmd, move_toward_max, move_count
//   res_ch    source   valid/ready       step/dir levels, position, count, flags
//   apb       slave    psel/penable      four 16-bit registers at 0x0..0xC
//
// Flow: an item is held in the input register, then the engine updates its state
// and the result register together as the item moves on; a new item is taken
// every clock while results drain.
// Reset: rst_n clears both valid bits, the motion state and the registers to
// their defaults at once; no clearing pass.
// Stalls: the result register holds while res_ch.ready is low; the input
// register then fills, and cmd_ch.ready drops only when both are full.
module stepper_step_dir_pulser_top (
    input  logic                      clk,
    input  logic                      rst_n,
    sdp_cmd_if.sink                   cmd_ch,
    sdp_res_if.source                 res_ch,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sdp_pkg::AddrW-1:0] paddr,
    input  logic [sdp_pkg::DataW-1:0] pwdata,
    output logic [sdp_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import sdp_pkg::*;

    cfg_t  cfg;
    item_t in_item_reg, in_item_next;
    logic  in_vld_reg,  in_vld_next;
    res_t  out_res_reg, out_res_next;
    logic  out_vld_reg, out_vld_next;
    res_t  eng_res;
    logic  cmd_acc;
    logic  advance;

    sdp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held item through the engine when the result slot is free or
    // draining this cycle
    assign advance      = in_vld_reg & (~out_vld_reg | res_ch.ready);
    assign cmd_ch.ready = ~in_vld_reg | advance;
    assign cmd_acc      = cmd_ch.valid & cmd_ch.ready;

    sdp_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (eng_res)
    );

    always_comb
    begin
        // Input register: load on accept, drop when the item moves on
        in_item_next = in_item_reg;
        if (cmd_acc)
        begin
            in_item_next.cmd             = cmd_ch.cmd;
            in_item_next.move_toward_max = cmd_ch.move_toward_max;
            in_item_next.move_count      = cmd_ch.move_count;
        end
        if (cmd_acc)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        // Result register: capture the engine output, hold under stall
        out_res_next = advance ? eng_res : out_res_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (res_ch.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign res_ch.valid           = out_vld_reg;
    assign res_ch.step_level      = out_res_reg.step_level;
    assign res_ch.dir_level       = out_res_reg.dir_level;
    assign res_ch.position        = out_res_reg.position;
    assign res_ch.steps_remaining = out_res_reg.steps_remaining;
    assign res_ch.busy_res        = out_res_reg.busy_res;
    assign res_ch.move_rejected   = out_res_reg.move_rejected;
    assign res_ch.move_clamped    = out_res_reg.move_clamped;

endmodule

// ----- rtl/core/sdp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the pulse generator, bound to the top level.
// Depends on stepper_step_dir_pulser_top and its channel interfaces.
module sdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_position,
    input logic [15:0] out_steps
);

    // Output register is empty on the edge after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid after reset");

    // Input back-pressure only comes from a stalled, full result slot
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a stalled result");

    // An accepted item reaches the output register when the sink drains
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted item did not produce a result");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_position) && $stable(out_steps)))
        else $error("stalled result changed");

endmodule

bind stepper_step_dir_pulser_top sdp_checker u_sdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd_ch.valid),
    .in_ready     (cmd_ch.ready),
    .out_valid    (res_ch.valid),
    .out_ready    (res_ch.ready),
    .out_position (res_ch.position),
    .out_steps    (res_ch.steps_remaining)
);
